@@ design/dflp_pkg.sv @@
// Shared types and codes for the deductive fault list propagation block.
`timescale 1ns / 1ps

package dflp_pkg;

    localparam int NETS_DEF = 32;
    localparam int NET_W    = 5;
    localparam int GATE_W   = 3;
    localparam int LIST_W   = 64;

    typedef enum logic [1:0] {
        KIND_INIT = 2'd0,
        KIND_EVAL = 2'd1,
        KIND_ACC  = 2'd2,
        KIND_CLR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_OUT_UPD = 2'd1,
        ST_NOT_RDY = 2'd2,
        ST_UNSUP   = 2'd3
    } t_status;

    localparam logic [GATE_W-1:0] GT_BUF  = 3'd0;
    localparam logic [GATE_W-1:0] GT_INV  = 3'd1;
    localparam logic [GATE_W-1:0] GT_AND  = 3'd2;
    localparam logic [GATE_W-1:0] GT_OR   = 3'd3;
    localparam logic [GATE_W-1:0] GT_NAND = 3'd4;
    localparam logic [GATE_W-1:0] GT_NOR  = 3'd5;

    typedef struct packed {
        t_kind              kind;
        logic [NET_W-1:0]   net_a;
        logic [NET_W-1:0]   net_b;
        logic [NET_W-1:0]   net_out;
        logic [GATE_W-1:0]  gate_type;
        logic               good_value;
        logic               is_primary;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [LIST_W-1:0]  fault_list;
    } t_out_item;

endpackage

@@ design/dflp_list_ram.sv @@
// Per-net list memory: good value and fault list, one write and two registered read ports.
`timescale 1ns / 1ps

module dflp_list_ram #(
    parameter int NETS = dflp_pkg::NETS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [$clog2(NETS)-1:0]      i_wr_addr,
    input  logic [2*NETS:0]              i_wr_data,
    input  logic                         i_rd0_en,
    input  logic [$clog2(NETS)-1:0]      i_rd0_addr,
    output logic [2*NETS:0]              o_rd0_data,
    input  logic                         i_rd1_en,
    input  logic [$clog2(NETS)-1:0]      i_rd1_addr,
    output logic [2*NETS:0]              o_rd1_data
);
    localparam int DW = 2 * NETS + 1;

    logic [DW-1:0] r_mem [NETS];
    logic          r_vld [NETS];
    logic [DW-1:0] r_rd0;
    logic [DW-1:0] r_rd1;
    logic          r_rd0_vld;
    logic          r_rd1_vld;

    // Entries never written read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '{default: 1'b0};
            r_rd0_vld <= 1'b0;
            r_rd1_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd0_en) begin
                r_rd0_vld <= r_vld[i_rd0_addr];
            end
            if (i_rd1_en) begin
                r_rd1_vld <= r_vld[i_rd1_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd0_en) begin
            r_rd0 <= r_mem[i_rd0_addr];
        end
        if (i_rd1_en) begin
            r_rd1 <= r_mem[i_rd1_addr];
        end
    end

    assign o_rd0_data = r_rd0_vld ? r_rd0 : '0;
    assign o_rd1_data = r_rd1_vld ? r_rd1 : '0;

endmodule

@@ design/deductive_fault_list_propagation.sv @@
// Top level of the deductive stuck-at fault list propagation block.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one command
//   transaction: init a net, evaluate a gate, accumulate a net's list into
//   the detected set, or clear that set. Output channel (o_out_valid /
//   i_out_ready / o_out_data) returns exactly one transaction per command
//   with a status code and a 64-bit list (upper bits zero when 2*NETS < 64).
//   The block takes no new command until the last one has finished: it is
//   ready only in S_IDLE. The list memory is read at the accept edge
//   (output net and first input), once more in S_RD1 (second input), and
//   written back when S_CALC finishes, so the next command enters once
//   the write has landed and sees it.
//   The output register parts the two sides: a finished result may wait
//   while the block sits idle and takes the next command. If a result is
//   still pending when the next one finishes, the block holds in its last
//   step until the receiver drains the register.
//   Reset (synchronous, active low) clears the updated flags, the
//   detected set and the memory's written marks, so every list, good value
//   and flag reads as zero afterwards; no clearing pass is needed.

module deductive_fault_list_propagation #(
    parameter int NETS = dflp_pkg::NETS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dflp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dflp_pkg::t_out_item o_out_data
);
    import dflp_pkg::*;

    localparam int LW = 2 * NETS;
    localparam int DW = LW + 1;
    localparam int AW = $clog2(NETS);
    localparam int BW = $clog2(LW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD1,
        S_CALC
    } t_state;

    t_state          r_state;
    t_state          n_state;
    t_in_item        r_item;
    logic [DW-1:0]   r_la;
    logic            r_upd [NETS];
    logic [LW-1:0]   r_det;
    logic            r_out_vld;
    t_out_item       r_out;
    t_out_item       n_out;

    logic            w_acc;
    logic            w_fin;
    logic            w_rd0_en;
    logic [AW-1:0]   w_rd0_addr;
    logic [DW-1:0]   w_rd0_data;
    logic            w_rd1_en;
    logic [AW-1:0]   w_rd1_addr;
    logic [DW-1:0]   w_rd1_data;
    logic            w_wr_en;
    logic [AW-1:0]   w_wr_addr;
    logic [DW-1:0]   w_wr_data;
    logic            w_upd_val;
    logic [LW-1:0]   w_det_new;

    logic            w_a_ok;
    logic            w_b_ok;
    logic            w_o_ok;
    logic [AW-1:0]   w_a_idx;
    logic [AW-1:0]   w_b_idx;
    logic [AW-1:0]   w_o_idx;
    logic            w_a_rdy;
    logic            w_b_rdy;
    logic [LW-1:0]   w_la;
    logic [LW-1:0]   w_lb;
    logic [LW-1:0]   w_lo;
    logic            w_ctrl;
    logic            w_ac;
    logic            w_bc;
    logic [LW-1:0]   w_gate;
    logic [BW-1:0]   w_bit;
    logic [LW-1:0]   w_init_list;
    logic [LW-1:0]   w_res_list;
    t_status         w_res_st;

    function automatic logic f_ok(input logic [NET_W-1:0] n);
        return int'(n) < NETS;
    endfunction

    function automatic logic [AW-1:0] f_idx(input logic [NET_W-1:0] n);
        return f_ok(n) ? n[AW-1:0] : '0;
    endfunction

    // Handshake and sequencing.
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_fin       = (r_state == S_CALC) && (!r_out_vld || i_out_ready);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Port 0 fetches the output net, port 1 the first input then the second.
    assign w_rd0_en   = w_acc;
    assign w_rd0_addr = f_idx(i_in_data.net_out);
    assign w_rd1_en   = w_acc || (r_state == S_RD1);
    assign w_rd1_addr = (r_state == S_RD1) ? f_idx(r_item.net_b) : f_idx(i_in_data.net_a);

    dflp_list_ram #(
        .NETS(NETS)
    ) u_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_data  (w_wr_data),
        .i_rd0_en   (w_rd0_en),
        .i_rd0_addr (w_rd0_addr),
        .o_rd0_data (w_rd0_data),
        .i_rd1_en   (w_rd1_en),
        .i_rd1_addr (w_rd1_addr),
        .o_rd1_data (w_rd1_data)
    );

    // Operand decode for the command held in r_item.
    assign w_a_ok  = f_ok(r_item.net_a);
    assign w_b_ok  = f_ok(r_item.net_b);
    assign w_o_ok  = f_ok(r_item.net_out);
    assign w_a_idx = f_idx(r_item.net_a);
    assign w_b_idx = f_idx(r_item.net_b);
    assign w_o_idx = f_idx(r_item.net_out);
    assign w_a_rdy = w_a_ok && r_upd[w_a_idx];
    assign w_b_rdy = w_b_ok && r_upd[w_b_idx];

    assign w_la = r_la[LW-1:0];
    assign w_lb = w_rd1_data[LW-1:0];
    assign w_lo = w_rd0_data[LW-1:0];

    // Controlling value is 1 for or/nor, 0 for and/nand.
    assign w_ctrl = (r_item.gate_type == GT_OR) || (r_item.gate_type == GT_NOR);
    assign w_ac   = (r_la[LW] == w_ctrl);
    assign w_bc   = (w_rd1_data[LW] == w_ctrl);

    always_comb begin
        case (r_item.gate_type)
            GT_BUF, GT_INV: begin
                w_gate = w_la;
            end
            default: begin
                if (w_ac && w_bc) begin
                    w_gate = w_la & w_lb;
                end else if (w_ac) begin
                    w_gate = w_la & ~w_lb;
                end else if (w_bc) begin
                    w_gate = w_lb & ~w_la;
                end else begin
                    w_gate = w_la | w_lb;
                end
            end
        endcase
    end

    // Init list: the net's own fault opposite to its good value.
    assign w_bit       = r_item.good_value ? BW'(w_a_idx) : BW'(w_a_idx) + BW'(NETS);
    assign w_init_list = {{(LW-1){1'b0}}, 1'b1} << w_bit;

    // Command evaluation and write-back selection.
    always_comb begin
        w_res_st   = ST_DONE;
        w_res_list = '0;
        w_det_new  = r_det;
        w_wr_en    = 1'b0;
        w_wr_addr  = w_o_idx;
        w_wr_data  = {w_rd0_data[LW], w_gate | w_lo};
        w_upd_val  = 1'b1;
        unique case (r_item.kind)
            KIND_INIT: begin
                w_wr_addr = w_a_idx;
                w_wr_data = {r_item.good_value, w_init_list};
                w_upd_val = r_item.is_primary;
                if (w_a_ok) begin
                    w_res_list = w_init_list;
                    w_wr_en    = w_fin;
                end
            end
            KIND_EVAL: begin
                if (!w_o_ok) begin
                    w_res_st = ST_UNSUP;
                end else if (r_upd[w_o_idx]) begin
                    w_res_st   = ST_OUT_UPD;
                    w_res_list = w_lo;
                end else if (r_item.gate_type > GT_NOR) begin
                    w_res_st   = ST_UNSUP;
                    w_res_list = w_lo;
                end else if (!w_a_rdy || (r_item.gate_type >= GT_AND && !w_b_rdy)) begin
                    w_res_st   = ST_NOT_RDY;
                    w_res_list = w_lo;
                end else begin
                    w_res_list = w_gate | w_lo;
                    w_wr_en    = w_fin;
                end
            end
            KIND_ACC: begin
                w_det_new  = w_a_ok ? (r_det | w_la) : r_det;
                w_res_list = w_det_new;
            end
            KIND_CLR: begin
                w_det_new = '0;
            end
            default: begin
                w_res_st = ST_DONE;
            end
        endcase
        n_out.status     = w_res_st;
        n_out.fault_list = LIST_W'(w_res_list);
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = w_acc ? S_RD1 : S_IDLE;
            S_RD1:   n_state = S_CALC;
            S_CALC:  n_state = w_fin ? S_IDLE : S_CALC;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_det     <= '0;
            r_upd     <= '{default: 1'b0};
        end else begin
            r_state <= n_state;
            if (w_fin) begin
                r_out_vld <= 1'b1;
                r_det     <= w_det_new;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_wr_en) begin
                r_upd[w_wr_addr] <= w_upd_val;
            end
        end
        // Payload: no reset.
        if (w_acc) begin
            r_item <= i_in_data;
        end
        if (r_state == S_RD1) begin
            r_la <= w_rd1_data;
        end
        if (w_fin) begin
            r_out <= n_out;
        end
    end

    // An accepted command always moves on to the second read.
    a_acc_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state == S_RD1))
        else $error("accepted command did not advance to second read");

    // A finished command is presented on the next cycle.
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> o_out_valid)
        else $error("finished command not presented");

    // Only successful commands modify the list memory.
    a_wr_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (o_out_data.status == ST_DONE))
        else $error("memory written by a command that reported failure");

endmodule

@@ tb/tb_deductive_fault_list_propagation.sv @@
// Self-checking testbench for the deductive stuck-at fault list propagation block.
`timescale 1ns / 1ps

module tb_deductive_fault_list_propagation;

    import dflp_pkg::*;

    localparam int NETS = NETS_DEF;
    localparam logic [LIST_W-1:0] LIST_MASK =
        (2 * NETS >= LIST_W) ? '1 : ((64'd1 << (2 * NETS)) - 64'd1);

    // Gate type codes that the block rejects.
    localparam logic [GATE_W-1:0] GT_BAD_LO = 3'd6;
    localparam logic [GATE_W-1:0] GT_BAD_HI = 3'd7;

    localparam int N_DIR       = 25;
    localparam int N_RANDOM    = 1010;
    localparam int CALM_TAIL   = 120;  // transactions at the end with no idling
    localparam int HOLD_AT     = 200;  // result count that triggers the long hold-off
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 20;

    // One queued command; a fixed row carries a result typed in by hand.
    typedef struct {
        t_in_item  cmd;
        bit        fixed;
        t_out_item res;
    } t_cmd_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    deductive_fault_list_propagation #(
        .NETS (NETS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the block's storage, kept by the fault list predictor.
    logic [LIST_W-1:0] net_list [NETS];
    logic              net_val  [NETS];
    logic              net_upd  [NETS];
    logic [LIST_W-1:0] seen_set;

    t_cmd_row  cmd_q[$];           // commands still to be offered
    t_out_item pending_lists[$];   // results owed by the block, oldest first

    int n_total    = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int errors     = 0;
    int st_seen [4];

    // Sender and receiver pacing.
    int send_gap   = 0;
    int send_quiet = 0;
    int recv_stall = 0;
    int recv_quiet = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    t_cmd_row  cur_row;
    t_out_item model_res;
    t_out_item want;

    // Apply one command to the shadow state and return the result it causes.
    function automatic t_out_item propagate_faults(t_in_item c);
        t_out_item         r;
        logic [LIST_W-1:0] la, lb, lo, t;
        logic              ctl;
        bit                ac, bc;
        r.status     = ST_DONE;
        r.fault_list = '0;
        case (c.kind)
            KIND_INIT: begin
                if (c.net_a < NETS) begin
                    // Own fault opposite to the good value.
                    r.fault_list = (64'd1 << (c.good_value ? int'(c.net_a)
                                                           : int'(c.net_a) + NETS))
                                   & LIST_MASK;
                    net_list[c.net_a] = r.fault_list;
                    net_val[c.net_a]  = c.good_value;
                    net_upd[c.net_a]  = c.is_primary;
                end
            end
            KIND_EVAL: begin
                if (c.net_out >= NETS) begin
                    r.status = ST_UNSUP;
                end else if (net_upd[c.net_out]) begin
                    r.status     = ST_OUT_UPD;
                    r.fault_list = net_list[c.net_out];
                end else if (c.gate_type > GT_NOR) begin
                    r.status     = ST_UNSUP;
                    r.fault_list = net_list[c.net_out];
                end else if (!(c.net_a < NETS && net_upd[c.net_a]) ||
                             (c.gate_type >= GT_AND &&
                              !(c.net_b < NETS && net_upd[c.net_b]))) begin
                    r.status     = ST_NOT_RDY;
                    r.fault_list = net_list[c.net_out];
                end else begin
                    la = net_list[c.net_a];
                    lo = net_list[c.net_out];
                    if (c.gate_type < GT_AND) begin
                        t = la;
                    end else begin
                        lb  = net_list[c.net_b];
                        ctl = (c.gate_type == GT_OR || c.gate_type == GT_NOR);
                        ac  = (net_val[c.net_a] == ctl);
                        bc  = (net_val[c.net_b] == ctl);
                        if (ac && bc)
                            t = la & lb;
                        else if (ac)
                            t = la & ~lb;
                        else if (bc)
                            t = lb & ~la;
                        else
                            t = la | lb;
                    end
                    r.fault_list          = (t | lo) & LIST_MASK;
                    net_list[c.net_out]   = r.fault_list;
                    net_upd[c.net_out]    = 1'b1;
                end
            end
            KIND_ACC: begin
                if (c.net_a < NETS)
                    seen_set = (seen_set | net_list[c.net_a]) & LIST_MASK;
                r.fault_list = seen_set;
            end
            default: begin
                seen_set = '0;
            end
        endcase
        return r;
    endfunction

    function automatic t_in_item mk_cmd(t_kind k, int a, int b, int o,
                                        logic [GATE_W-1:0] gt, bit gv, bit prim);
        t_in_item c;
        c.kind       = k;
        c.net_a      = a[NET_W-1:0];
        c.net_b      = b[NET_W-1:0];
        c.net_out    = o[NET_W-1:0];
        c.gate_type  = gt;
        c.good_value = gv;
        c.is_primary = prim;
        return c;
    endfunction

    function automatic t_cmd_row dir_row(t_kind k, int a, int b, int o,
                                         logic [GATE_W-1:0] gt, bit gv, bit prim,
                                         bit fixed, t_status st, logic [LIST_W-1:0] lst);
        t_cmd_row row;
        row.cmd            = mk_cmd(k, a, b, o, gt, gv, prim);
        row.fixed          = fixed;
        row.res.status     = st;
        row.res.fault_list = lst;
        return row;
    endfunction

    function automatic void queue_cmd(t_in_item c);
        t_cmd_row row;
        row.cmd   = c;
        row.fixed = 1'b0;
        row.res   = '0;
        cmd_q.push_back(row);
    endfunction

    // Random command with every field drawn over its whole range.
    function automatic t_in_item noise_cmd();
        return mk_cmd(t_kind'($urandom_range(0, 3)), $urandom_range(0, 31),
                      $urandom_range(0, 31), $urandom_range(0, 31),
                      GATE_W'($urandom_range(0, 7)), $urandom_range(0, 1),
                      $urandom_range(0, 1));
    endfunction

    // Sender: offer the head of the command queue, predict on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                cur_row   = cmd_q.pop_front();
                model_res = propagate_faults(cur_row.cmd);
                pending_lists.push_back(cur_row.fixed ? cur_row.res : model_res);
                n_accepted++;
                // Idle in bursts, with quiet stretches in between.
                if (send_quiet > 0)
                    send_quiet--;
                else if ($urandom_range(0, 9) == 0)
                    send_quiet = $urandom_range(20, 60);
                else if (n_accepted + CALM_TAIL < n_total && $urandom_range(0, 2) == 0)
                    send_gap = $urandom_range(1, 10);
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the transaction until it is taken
            end else if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= cmd_q[0].cmd;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: check every result against the oldest owed one, pace ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                st_seen[o_out_data.status]++;
                if (pending_lists.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing owed: status %0d list %h",
                             $time, o_out_data.status, o_out_data.fault_list);
                end else begin
                    want = pending_lists.pop_front();
                    if (want.status !== o_out_data.status) begin
                        errors++;
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, o_out_data.status);
                    end
                    if (want.fault_list !== o_out_data.fault_list) begin
                        errors++;
                        $display("%0t: fault list mismatch: expected %h actual %h",
                                 $time, want.fault_list, o_out_data.fault_list);
                    end
                end
            end
            if (recv_quiet > 0)
                recv_quiet--;
            else if ($urandom_range(0, 99) == 0)
                recv_quiet = $urandom_range(50, 150);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && n_results >= HOLD_AT) begin
                // Long hold-off: let the block fill up and back-pressure the sender.
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                i_out_ready <= 1'b0;
            end else if (recv_quiet == 0 && n_accepted + CALM_TAIL < n_total &&
                         $urandom_range(0, 5) == 0) begin
                recv_stall = $urandom_range(0, 9);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_cmd_row dir_tab [N_DIR];
        int       perm [32];
        int       ga [16];
        int       gb [16];
        int       gk [16];
        bit       gval [16];
        int       n_rand, npi, nint, nall, sw, tmp, k, a, b;
        logic [GATE_W-1:0] gt;

        for (int i = 0; i < NETS; i++) begin
            net_list[i] = '0;
            net_val[i]  = 1'b0;
            net_upd[i]  = 1'b0;
        end
        seen_set = '0;
        for (int i = 0; i < 4; i++)
            st_seen[i] = 0;

        // Directed part: reset state, edge nets, every gate and every status.
        dir_tab = '{
            dir_row(KIND_ACC,   0,  0,  0, GT_BUF,    0, 0, 1, ST_DONE,    64'h0),
            dir_row(KIND_EVAL,  0,  0,  5, GT_BUF,    0, 0, 1, ST_NOT_RDY, 64'h0),
            dir_row(KIND_EVAL,  0,  0,  6, GT_BAD_HI, 0, 0, 1, ST_UNSUP,   64'h0),
            dir_row(KIND_INIT,  0,  0,  0, GT_BUF,    1, 1, 1, ST_DONE,    64'h1),
            dir_row(KIND_INIT, 31,  0,  0, GT_BUF,    0, 1, 1, ST_DONE,
                    64'h8000_0000_0000_0000),
            dir_row(KIND_INIT,  1,  0,  0, GT_BUF,    0, 1, 1, ST_DONE,
                    64'h0000_0002_0000_0000),
            dir_row(KIND_INIT,  2,  0,  0, GT_BUF,    1, 0, 1, ST_DONE,    64'h4),
            dir_row(KIND_INIT,  3,  0,  0, GT_BUF,    0, 0, 1, ST_DONE,
                    64'h0000_0008_0000_0000),
            // net_b is don't-care for a buffer
            dir_row(KIND_EVAL,  0, 30,  2, GT_BUF,    0, 0, 1, ST_DONE,    64'h5),
            dir_row(KIND_EVAL,  0,  0,  2, GT_BUF,    0, 0, 1, ST_OUT_UPD, 64'h5),
            dir_row(KIND_EVAL, 31,  0,  3, GT_INV,    0, 0, 0, ST_DONE,    64'h0),
            dir_row(KIND_INIT,  4,  0,  0, GT_BUF,    0, 0, 1, ST_DONE,
                    64'h0000_0010_0000_0000),
            // one input at the controlling value
            dir_row(KIND_EVAL,  0,  1,  4, GT_AND,    0, 0, 0, ST_DONE,    64'h0),
            dir_row(KIND_INIT,  5,  0,  0, GT_BUF,    1, 0, 1, ST_DONE,    64'h20),
            dir_row(KIND_EVAL,  0, 31,  5, GT_OR,     0, 0, 0, ST_DONE,    64'h0),
            dir_row(KIND_INIT,  6,  0,  0, GT_BUF,    1, 0, 0, ST_DONE,    64'h0),
            // both inputs at the controlling value
            dir_row(KIND_EVAL,  1, 31,  6, GT_NAND,   0, 0, 0, ST_DONE,    64'h0),
            dir_row(KIND_INIT,  7,  0,  0, GT_BUF,    0, 0, 0, ST_DONE,    64'h0),
            // neither input at the controlling value
            dir_row(KIND_EVAL,  1, 31,  7, GT_NOR,    0, 0, 0, ST_DONE,    64'h0),
            dir_row(KIND_EVAL,  0,  2,  8, GT_AND,    0, 0, 0, ST_DONE,    64'h0),
            dir_row(KIND_EVAL,  0,  0,  9, GT_BAD_LO, 0, 0, 1, ST_UNSUP,   64'h0),
            dir_row(KIND_EVAL,  0,  9, 10, GT_AND,    0, 0, 1, ST_NOT_RDY, 64'h0),
            dir_row(KIND_ACC,   3,  0,  0, GT_BUF,    0, 0, 0, ST_DONE,    64'h0),
            dir_row(KIND_ACC,  31,  0,  0, GT_BUF,    0, 0, 0, ST_DONE,    64'h0),
            dir_row(KIND_CLR,   0,  0,  0, GT_BUF,    0, 0, 1, ST_DONE,    64'h0)
        };
        for (int i = 0; i < N_DIR; i++)
            cmd_q.push_back(dir_tab[i]);

        // Random part: mostly small well-formed circuits, some noise.
        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 5)) begin
                    queue_cmd(noise_cmd());
                    n_rand++;
                end
            end else begin
                for (int i = 0; i < 32; i++)
                    perm[i] = i;
                for (int i = 31; i > 0; i--) begin
                    sw       = $urandom_range(0, i);
                    tmp      = perm[i];
                    perm[i]  = perm[sw];
                    perm[sw] = tmp;
                end
                npi  = $urandom_range(2, 6);
                nint = $urandom_range(2, 8);
                nall = npi + nint;
                for (int i = 0; i < npi; i++)
                    gval[i] = $urandom_range(0, 1);
                // Gates in topological order; good values follow the logic.
                for (int j = npi; j < nall; j++) begin
                    gk[j] = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 7)
                                                          : $urandom_range(0, 5);
                    ga[j] = $urandom_range(0, j - 1);
                    gb[j] = $urandom_range(0, j - 1);
                    // occasionally wire in a net that is not evaluated yet
                    if ($urandom_range(0, 15) == 0)
                        ga[j] = $urandom_range(j, nall - 1);
                    case (GATE_W'(gk[j]))
                        GT_BUF:  gval[j] = gval[ga[j]];
                        GT_INV:  gval[j] = !gval[ga[j]];
                        GT_AND:  gval[j] = gval[ga[j]] & gval[gb[j]];
                        GT_OR:   gval[j] = gval[ga[j]] | gval[gb[j]];
                        GT_NAND: gval[j] = !(gval[ga[j]] & gval[gb[j]]);
                        GT_NOR:  gval[j] = !(gval[ga[j]] | gval[gb[j]]);
                        default: gval[j] = $urandom_range(0, 1);
                    endcase
                end
                for (int i = 0; i < nall; i++) begin
                    queue_cmd(mk_cmd(KIND_INIT, perm[i], $urandom_range(0, 31),
                                     $urandom_range(0, 31), GATE_W'($urandom_range(0, 7)),
                                     gval[i], i < npi));
                    n_rand++;
                end
                for (int j = npi; j < nall; j++) begin
                    gt = GATE_W'(gk[j]);
                    b  = (gt < GT_AND) ? $urandom_range(0, 31) : perm[gb[j]];
                    queue_cmd(mk_cmd(KIND_EVAL, perm[ga[j]], b, perm[j], gt,
                                     $urandom_range(0, 1), $urandom_range(0, 1)));
                    n_rand++;
                end
                if ($urandom_range(0, 2) == 0) begin
                    k = $urandom_range(npi, nall - 1);
                    queue_cmd(mk_cmd(KIND_EVAL, perm[ga[k]], perm[gb[k]], perm[k],
                                     GATE_W'(gk[k]), 0, 0));
                    n_rand++;
                end
                if ($urandom_range(0, 3) == 0) begin
                    queue_cmd(mk_cmd(KIND_CLR, $urandom_range(0, 31), $urandom_range(0, 31),
                                     $urandom_range(0, 31), GATE_W'($urandom_range(0, 7)),
                                     $urandom_range(0, 1), $urandom_range(0, 1)));
                    n_rand++;
                end
                repeat ($urandom_range(1, 3)) begin
                    a = perm[$urandom_range(npi, nall - 1)];
                    queue_cmd(mk_cmd(KIND_ACC, a, 0, 0, GT_BUF, 0, 0));
                    n_rand++;
                end
            end
        end
        n_total = cmd_q.size();

        // Single synchronous reset at the start of the run.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total)
            @(negedge i_clk);
        while (pending_lists.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("Ran %0d directed and %0d random fault list commands, %0d results.",
                 N_DIR, n_total - N_DIR, n_results);
        $display("Status mix: done %0d, output updated %0d, inputs not ready %0d, unsupported %0d.",
                 st_seen[ST_DONE], st_seen[ST_OUT_UPD], st_seen[ST_NOT_RDY],
                 st_seen[ST_UNSUP]);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
